/* hw/rtl/sbps_pkg.sv */
// ----------------------------------------------------------------------------
// sbps_pkg
// Types and constants shared by the six-button pad scanner.
// ----------------------------------------------------------------------------
package sbps_pkg;

    // raw pad line levels for one tick, low means pressed
    typedef struct packed {
        logic line_up;
        logic line_down;
        logic line_left;
        logic line_right;
        logic line_tl;
        logic line_tr;
    } pad_lines_t;

    // one result per tick
    typedef struct packed {
        logic        select_level;
        logic [11:0] buttons;
        logic        six_button;
        logic        scan_done;
    } scan_result_t;

    // configuration register indexes
    localparam logic [1:0] REG_SETTLE_TICKS = 2'd0;
    localparam logic [1:0] REG_PAUSE_TICKS  = 2'd1;
    localparam logic [1:0] REG_SWAP_ROWS    = 2'd2;

    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [9:0]  SETTLE_RESET = 10'd10;
    localparam logic [15:0] PAUSE_RESET  = 16'd2000;

    // bit positions in the buttons word
    localparam logic [3:0] BIT_UP    = 4'd0;
    localparam logic [3:0] BIT_DOWN  = 4'd1;
    localparam logic [3:0] BIT_LEFT  = 4'd2;
    localparam logic [3:0] BIT_RIGHT = 4'd3;
    localparam logic [3:0] BIT_B1    = 4'd4;
    localparam logic [3:0] BIT_B2    = 4'd5;
    localparam logic [3:0] BIT_B3    = 4'd6;
    localparam logic [3:0] BIT_B4    = 4'd7;
    localparam logic [3:0] BIT_B5    = 4'd8;
    localparam logic [3:0] BIT_B6    = 4'd9;
    localparam logic [3:0] BIT_START = 4'd10;
    localparam logic [3:0] BIT_COIN  = 4'd11;

endpackage

/* hw/rtl/six_button_pad_scanner_unit.sv */
// ----------------------------------------------------------------------------
// six_button_pad_scanner_unit
// Free-running scan of a multiplexed six-button game pad, one tick per request.
// ----------------------------------------------------------------------------
//
//   channel   | direction | payload         | meaning
//   ----------+-----------+-----------------+-----------------------------------
//   s_        | in        | pad_lines_t     | one tick with the sampled pad lines
//   m_        | out       | scan_result_t   | select level, buttons, status
//   cfg_      | in        | index + data    | settle, pause and swap registers
//
// every input request yields exactly one result request
// the whole tick update (phase, wait counter, button word) is one pass of
// logic from the state registers into the result register, so a new request
// is taken in every cycle while the result register is free or being drained
// a stalled result holds s_ready low only when the result register is full
// and m_ready is low; reset is synchronous, active low on aresetn
// ----------------------------------------------------------------------------
module six_button_pad_scanner_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // pad tick requests
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sbps_pkg::pad_lines_t        s_data,
    // scan results
    output logic                        m_valid,
    input  logic                        m_ready,
    output sbps_pkg::scan_result_t      m_data,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [sbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sbps_pkg::*;

    // scan phases
    localparam logic [2:0] PH_HIGH0  = 3'd0;  // directions, B C
    localparam logic [2:0] PH_LOW1   = 3'd1;  // A, start
    localparam logic [2:0] PH_HIGH2  = 3'd2;  // no sample
    localparam logic [2:0] PH_DETECT = 3'd3;  // six-button detection
    localparam logic [2:0] PH_EXTRA  = 3'd4;  // X Y Z and mode
    localparam logic [2:0] PH_LOW5   = 3'd5;
    localparam logic [2:0] PH_END6   = 3'd6;  // six-button scan ends
    localparam logic [2:0] PH_PAUSE  = 3'd7;  // idle with select low

    // configuration
    logic [9:0]  settle_reg;
    logic [15:0] pause_reg;
    logic        swap_reg;

    // scan state
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] wait_reg, wait_next;
    logic [11:0] buttons_reg, buttons_next;
    logic        six_reg, six_next;
    logic        done;
    logic        sel;

    // result register
    logic         m_valid_reg;
    scan_result_t m_data_reg;

    // pressed levels for this tick
    logic up, down, left, right, tl, tr;
    logic [15:0] len;
    logic        phase_end;
    logic        accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign up    = ~s_data.line_up;
    assign down  = ~s_data.line_down;
    assign left  = ~s_data.line_left;
    assign right = ~s_data.line_right;
    assign tl    = ~s_data.line_tl;
    assign tr    = ~s_data.line_tr;

    // even phases drive select high
    assign sel = ~phase_reg[0];

    // phase length, a settle of zero acts as one
    always_comb begin
        if (phase_reg == PH_PAUSE) begin
            len = pause_reg;
        end else if (settle_reg == 10'd0) begin
            len = 16'd1;
        end else begin
            len = {6'd0, settle_reg};
        end
    end

    // the phase ends once the tick count reaches the current length
    assign phase_end = ({1'b0, wait_reg} + 17'd1) >= {1'b0, len};

    always_comb begin
        phase_next   = phase_reg;
        wait_next    = wait_reg;
        buttons_next = buttons_reg;
        six_next     = six_reg;
        done         = 1'b0;
        if (phase_reg == PH_PAUSE && len == 16'd0) begin
            // pause cleared while pausing: restart the scan at once
            phase_next = PH_HIGH0;
            wait_next  = 16'd0;
        end else if (phase_end) begin
            wait_next = 16'd0;
            case (phase_reg)
                PH_HIGH0: begin
                    buttons_next[BIT_UP]    = up;
                    buttons_next[BIT_DOWN]  = down;
                    buttons_next[BIT_LEFT]  = left;
                    buttons_next[BIT_RIGHT] = right;
                    buttons_next[swap_reg ? BIT_B5 : BIT_B2] = tl;
                    buttons_next[swap_reg ? BIT_B6 : BIT_B3] = tr;
                    phase_next = PH_LOW1;
                end
                PH_LOW1: begin
                    buttons_next[swap_reg ? BIT_B4 : BIT_B1] = tl;
                    buttons_next[BIT_START] = tr;
                    phase_next = PH_HIGH2;
                end
                PH_HIGH2: begin
                    phase_next = PH_DETECT;
                end
                PH_DETECT: begin
                    // all four directions low marks a six-button pad
                    if (up && down && left && right) begin
                        six_next   = 1'b1;
                        phase_next = PH_EXTRA;
                    end else begin
                        six_next   = 1'b0;
                        phase_next = PH_HIGH0;
                        done       = 1'b1;
                    end
                end
                PH_EXTRA: begin
                    buttons_next[swap_reg ? BIT_B3 : BIT_B6] = up;
                    buttons_next[swap_reg ? BIT_B2 : BIT_B5] = down;
                    buttons_next[swap_reg ? BIT_B1 : BIT_B4] = left;
                    buttons_next[BIT_COIN] = right;
                    phase_next = PH_LOW5;
                end
                PH_LOW5: begin
                    phase_next = PH_END6;
                end
                PH_END6: begin
                    done       = 1'b1;
                    phase_next = (pause_reg == 16'd0) ? PH_HIGH0 : PH_PAUSE;
                end
                default: begin
                    phase_next = PH_HIGH0;
                end
            endcase
        end else begin
            wait_next = wait_reg + 16'd1;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_RESET;
            pause_reg  <= PAUSE_RESET;
            swap_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SETTLE_TICKS: settle_reg <= cfg_wdata[9:0];
                REG_PAUSE_TICKS:  pause_reg  <= cfg_wdata;
                REG_SWAP_ROWS:    swap_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // scan state advances once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HIGH0;
            wait_reg    <= 16'd0;
            buttons_reg <= 12'd0;
            six_reg     <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            wait_reg    <= wait_next;
            buttons_reg <= buttons_next;
            six_reg     <= six_next;
        end
    end

    // result register, valid flag under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.select_level <= sel;
            m_data_reg.buttons      <= buttons_next;
            m_data_reg.six_button   <= six_next;
            m_data_reg.scan_done    <= done;
        end
    end

endmodule
